[hw/rtl/mesfs_pkg.sv]
// Shared constants and types of the elementary stream frame splitter.
`timescale 1ns / 1ps
package mesfs_pkg;

  localparam int SmallVopLimit = 20;
  localparam int HoldDepth     = 24;
  localparam int CaptureDepth  = 20;
  localparam int LengthCap     = 63;
  localparam int VbvParamBits  = 79;
  localparam int QDepth        = 4;

  localparam int LenW  = $clog2(LengthCap + 1);
  localparam int HIdxW = $clog2(HoldDepth);
  localparam int CIdxW = $clog2(CaptureDepth);
  localparam int PosW  = $clog2(HoldDepth * 8 + 64);
  localparam int QIdxW = $clog2(QDepth);

  localparam logic [7:0] NoCode   = 8'hff;
  localparam logic [7:0] VosCode  = 8'hb0;
  localparam logic [7:0] GvopCode = 8'hb3;
  localparam logic [7:0] VopCode  = 8'hb6;
  localparam logic [7:0] VoLast   = 8'h1f;
  localparam logic [7:0] VolFirst = 8'h20;
  localparam logic [7:0] VolLast  = 8'h2f;

  localparam logic [1:0] PrefixSeen = 2'd3;

  typedef enum logic [1:0] {
    CmdNop,
    CmdData,
    CmdStart,
    CmdFinish
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic [1:0]  zeros;
    logic        eod;
    logic [1:0]  eod_match;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_frame_end;
    logic       last;
  } result_t;

endpackage

[hw/rtl/mesfs_cmd_queue.sv]
// Short command queue between the prefix classifier and the unit engine.
`timescale 1ns / 1ps
module mesfs_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mesfs_pkg::cmd_t   data_i,
  output logic              full_o,
  input  logic              pop_i,
  output mesfs_pkg::cmd_t   data_o,
  output logic              empty_o
);
  import mesfs_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QIdxW-1:0] wptr_q, rptr_q;
  logic [QIdxW:0]   count_q;

  assign full_o  = (count_q == (QIdxW+1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i) rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

[hw/rtl/mesfs_res_queue.sv]
// Result queue that presents finished result items to the receiver.
`timescale 1ns / 1ps
module mesfs_res_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mesfs_pkg::result_t  data_i,
  output logic                full_o,
  input  logic                pop_i,
  output mesfs_pkg::result_t  data_o,
  output logic                empty_o
);
  import mesfs_pkg::*;

  result_t          mem_q [QDepth];
  logic [QIdxW-1:0] wptr_q, rptr_q;
  logic [QIdxW:0]   count_q;
  logic             do_pop;

  assign full_o  = (count_q == (QIdxW+1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (do_pop) rptr_q <= rptr_q + 1'b1;
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

[hw/rtl/mesfs_front.sv]
// Start code prefix tracker that turns each stream byte into one engine command.
`timescale 1ns / 1ps
module mesfs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       stream_byte_i,
  input  logic             end_of_data_i,
  output mesfs_pkg::cmd_t  cmd_o
);
  import mesfs_pkg::*;

  logic [1:0] match_q, match_d, match_n;
  cmd_t       cmd;

  always_comb begin
    cmd.kind      = CmdData;
    cmd.data      = stream_byte_i;
    cmd.zeros     = 2'd0;
    cmd.eod       = end_of_data_i;
    match_n       = 2'd0;
    if (match_q == PrefixSeen) begin
      cmd.kind = CmdStart;
    end else if (stream_byte_i == 8'h00) begin
      if (match_q < 2'd2) begin
        cmd.kind = CmdNop;
        match_n  = match_q + 2'd1;
      end else begin
        // A third zero commits the oldest pending one.
        match_n = 2'd2;
      end
    end else if (stream_byte_i == 8'h01 && match_q == 2'd2) begin
      cmd.kind = CmdFinish;
      match_n  = PrefixSeen;
    end else begin
      cmd.zeros = match_q;
    end
    cmd.eod_match = match_n;
    match_d = match_q;
    if (accept_i) match_d = end_of_data_i ? 2'd0 : match_n;
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 2'd0;
    end else begin
      match_q <= match_d;
    end
  end

endmodule

[hw/rtl/mesfs_back.sv]
// Unit engine: commits bytes, holds small VOP units, parses VOL headers, emits results.
`timescale 1ns / 1ps
module mesfs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mesfs_pkg::cmd_t     cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  output mesfs_pkg::result_t  res_o,
  output logic                res_push_o,
  input  logic                res_full_i
);
  import mesfs_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_COMMIT  = 4'd1;
  localparam logic [3:0] S_FLUSH   = 4'd2;
  localparam logic [3:0] S_MARK    = 4'd3;
  localparam logic [3:0] S_HDR     = 4'd4;
  localparam logic [3:0] S_FIN     = 4'd5;
  localparam logic [3:0] S_VC      = 4'd6;
  localparam logic [3:0] S_VC2     = 4'd7;
  localparam logic [3:0] S_VOL     = 4'd8;
  localparam logic [3:0] S_FIN_END = 4'd9;
  localparam logic [3:0] S_TAIL    = 4'd10;
  localparam logic [3:0] S_EKEEP   = 4'd11;
  localparam logic [3:0] S_EMARK   = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  localparam logic [2:0] VS_OID   = 3'd0;
  localparam logic [2:0] VS_VERID = 3'd1;
  localparam logic [2:0] VS_ARI   = 3'd2;
  localparam logic [2:0] VS_VCP   = 3'd3;
  localparam logic [2:0] VS_VBV   = 3'd4;
  localparam logic [2:0] VS_SHAPE = 3'd5;
  localparam logic [2:0] VS_RES   = 3'd6;

  logic [3:0]       st_q, st_d, fret_q, fret_d;
  cmd_t             cmd_q, cmd_d;
  logic             ph_q, ph_d;
  logic [1:0]       zcnt_q, zcnt_d, k_q, k_d;
  logic [HIdxW-1:0] fidx_q, fidx_d;
  logic [PosW-1:0]  pos_q, pos_d, skip;
  logic [15:0]      acc_q, acc_d, nacc, resm1;
  logic [4:0]       rcnt_q, rcnt_d, inc_q, inc_d, nbits;
  logic [2:0]       vstep_q, vstep_d;
  logic [3:0]       verid_q, verid_d;
  logic [7:0]       unit_q, unit_d, prev_q, prev_d, cx, code;
  logic [LenW-1:0]  len_q, len_d, cap_off;
  logic             fhb_q, fhb_d;
  logic [7:0]       hold_q [HoldDepth];
  logic [7:0]       hold_d [HoldDepth];
  logic [7:0]       cap_q [CaptureDepth];
  logic [7:0]       cap_d [CaptureDepth];
  result_t          stage_q, stage_d, emit_r;
  logic             stage_v_q, stage_v_d, emit_v, en;
  logic             holding, is_vol, do_commit, hbit, cbit, setc, after_vop;
  logic [3:0]       nxt;
  logic [PosW-4:0]  hb_byte;

  assign en       = !(stage_v_q && res_full_i);
  assign holding  = (unit_q == VopCode) && (int'(len_q) < SmallVopLimit);
  assign is_vol   = (unit_q >= VolFirst) && (unit_q <= VolLast);
  assign hb_byte  = pos_q[PosW-1:3];
  assign hbit     = (int'(hb_byte) < int'(len_q)) && (int'(hb_byte) < HoldDepth)
                    && hold_q[hb_byte[HIdxW-1:0]][~pos_q[2:0]];
  assign cbit     = (int'(hb_byte) < CaptureDepth) && cap_q[hb_byte[CIdxW-1:0]][~pos_q[2:0]];
  assign cap_off  = len_q - LenW'(4);
  assign code     = cmd_q.data;

  always_comb begin
    st_d = st_q;  fret_d = fret_q;  cmd_d = cmd_q;  ph_d = ph_q;
    zcnt_d = zcnt_q;  k_d = k_q;  fidx_d = fidx_q;  pos_d = pos_q;
    acc_d = acc_q;  rcnt_d = rcnt_q;  inc_d = inc_q;  vstep_d = vstep_q;
    verid_d = verid_q;  unit_d = unit_q;  prev_d = prev_q;  len_d = len_q;
    fhb_d = fhb_q;  hold_d = hold_q;  cap_d = cap_q;
    emit_v = 1'b0;  emit_r = '0;
    do_commit = 1'b0;  cx = 8'h00;  nxt = S_TAIL;  skip = '0;
    nacc = {acc_q[14:0], cbit};  resm1 = nacc - 16'd1;  nbits = 5'd0;
    setc = (code == VosCode) || (code == GvopCode) || (code == VopCode) || (code <= VoLast);
    after_vop = (prev_q == VopCode) || ((prev_q == NoCode) && (code == VopCode));
    for (int i = 0; i < 16; i++) begin
      if (resm1[i]) nbits = 5'(i + 1);
    end

    case (st_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_d  = cmd_i;
          ph_d   = 1'b0;
          zcnt_d = cmd_i.zeros;
          case (cmd_i.kind)
            CmdNop:    st_d = S_TAIL;
            CmdData:   st_d = S_COMMIT;
            CmdStart:  st_d = S_MARK;
            CmdFinish: st_d = S_FIN;
            default:   st_d = S_TAIL;
          endcase
        end
      end
      S_COMMIT: begin
        if (zcnt_q != 2'd0) begin
          do_commit = 1'b1;
          zcnt_d    = zcnt_q - 2'd1;
          nxt       = S_COMMIT;
        end else if (!ph_q) begin
          do_commit = 1'b1;
          cx        = cmd_q.data;
          nxt       = S_TAIL;
        end else begin
          st_d = S_FIN;
        end
        if (do_commit) begin
          if (holding) begin
            if (int'(len_q) < HoldDepth) hold_d[len_q[HIdxW-1:0]] = cx;
            len_d = len_q + 1'b1;
            if (int'(len_q) + 1 >= SmallVopLimit) begin
              st_d   = S_FLUSH;
              fidx_d = '0;
              fret_d = nxt;
            end else begin
              st_d = nxt;
            end
          end else begin
            if (is_vol && int'(len_q) >= 4 && int'(cap_off) < CaptureDepth) begin
              cap_d[cap_off[CIdxW-1:0]] = cx;
            end
            emit_v = 1'b1;
            emit_r.out_byte = cx;
            fhb_d = 1'b1;
            if (int'(len_q) < LengthCap) len_d = len_q + 1'b1;
            st_d = nxt;
          end
        end
      end
      S_FLUSH: begin
        emit_v = 1'b1;
        emit_r.out_byte = hold_q[fidx_q];
        fhb_d = 1'b1;
        if ((int'(fidx_q) + 1 >= int'(len_q)) || (int'(fidx_q) + 1 >= HoldDepth)) begin
          st_d = fret_q;
        end else begin
          fidx_d = fidx_q + 1'b1;
        end
      end
      S_MARK: begin
        if (fhb_q && setc && after_vop) begin
          emit_v = 1'b1;
          emit_r.is_frame_end = 1'b1;
          fhb_d = 1'b0;
        end
        unit_d = code;
        len_d  = LenW'(4);
        if (code >= VolFirst && code <= VolLast) begin
          for (int i = 0; i < CaptureDepth; i++) cap_d[i] = 8'h00;
        end
        if (code == VopCode) begin
          // A new VOP unit is always short at this point, so the header is held.
          hold_d[0] = 8'h00;
          hold_d[1] = 8'h00;
          hold_d[2] = 8'h01;
          hold_d[3] = code;
          st_d = S_TAIL;
        end else begin
          k_d  = 2'd0;
          st_d = S_HDR;
        end
      end
      S_HDR: begin
        emit_v = 1'b1;
        case (k_q)
          2'd0, 2'd1: emit_r.out_byte = 8'h00;
          2'd2:       emit_r.out_byte = 8'h01;
          default:    emit_r.out_byte = code;
        endcase
        fhb_d = 1'b1;
        k_d   = k_q + 2'd1;
        if (k_q == 2'd3) st_d = S_TAIL;
      end
      S_FIN: begin
        if (holding) begin
          pos_d = PosW'(34);
          st_d  = S_VC;
        end else if (is_vol) begin
          pos_d   = PosW'(9);
          vstep_d = VS_OID;
          rcnt_d  = 5'd1;
          verid_d = 4'd1;
          st_d    = S_VOL;
        end else begin
          st_d = S_FIN_END;
        end
      end
      S_VC: begin
        // Skip the modulo time base ones, then the marker, increment and marker bits.
        if (hbit) begin
          pos_d = pos_q + 1'b1;
        end else begin
          pos_d = pos_q + PosW'(3) + PosW'(inc_q);
          st_d  = S_VC2;
        end
      end
      S_VC2: begin
        if (hbit) begin
          st_d   = S_FLUSH;
          fidx_d = '0;
          fret_d = S_FIN_END;
        end else begin
          st_d = S_FIN_END;
        end
      end
      S_VOL: begin
        acc_d = nacc;
        if (rcnt_q != 5'd1) begin
          rcnt_d = rcnt_q - 5'd1;
        end else begin
          case (vstep_q)
            VS_OID: begin
              rcnt_d  = 5'd4;
              vstep_d = nacc[0] ? VS_VERID : VS_ARI;
            end
            VS_VERID: begin
              verid_d = nacc[3:0];
              skip    = PosW'(3);
              rcnt_d  = 5'd4;
              vstep_d = VS_ARI;
            end
            VS_ARI: begin
              if (nacc[3:0] == 4'hf) skip = PosW'(16);
              rcnt_d  = 5'd1;
              vstep_d = VS_VCP;
            end
            VS_VCP: begin
              if (nacc[0]) begin
                skip    = PosW'(3);
                rcnt_d  = 5'd1;
                vstep_d = VS_VBV;
              end else begin
                rcnt_d  = 5'd2;
                vstep_d = VS_SHAPE;
              end
            end
            VS_VBV: begin
              if (nacc[0]) skip = PosW'(VbvParamBits);
              rcnt_d  = 5'd2;
              vstep_d = VS_SHAPE;
            end
            VS_SHAPE: begin
              // Marker bit, plus the grayscale extension bits of later versions.
              skip = (nacc[1:0] == 2'd3 && verid_q != 4'd1) ? PosW'(5) : PosW'(1);
              rcnt_d  = 5'd16;
              vstep_d = VS_RES;
            end
            default: begin
              inc_d = (nbits == 5'd0) ? 5'd1 : nbits;
              st_d  = S_FIN_END;
            end
          endcase
        end
        pos_d = pos_q + PosW'(1) + skip;
      end
      S_FIN_END: begin
        if (!ph_q) begin
          prev_d = unit_q;
          unit_d = NoCode;
          len_d  = '0;
          st_d   = S_TAIL;
        end else begin
          st_d = S_EMARK;
        end
      end
      S_TAIL: begin
        if (!cmd_q.eod) begin
          st_d = S_DONE;
        end else begin
          ph_d = 1'b1;
          if (cmd_q.eod_match == PrefixSeen) begin
            k_d  = 2'd0;
            st_d = S_EKEEP;
          end else begin
            zcnt_d = cmd_q.eod_match;
            st_d   = S_COMMIT;
          end
        end
      end
      S_EKEEP: begin
        emit_v = 1'b1;
        emit_r.out_byte = (k_q == 2'd2) ? 8'h01 : 8'h00;
        fhb_d = 1'b1;
        k_d   = k_q + 2'd1;
        if (k_q == 2'd2) st_d = S_EMARK;
      end
      S_EMARK: begin
        if (fhb_q) begin
          emit_v = 1'b1;
          emit_r.is_frame_end = 1'b1;
        end
        unit_d = NoCode;
        prev_d = NoCode;
        len_d  = '0;
        fhb_d  = 1'b0;
        st_d   = S_DONE;
      end
      S_DONE: begin
        st_d = S_IDLE;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase

    // The newest result waits in the stage until it is known whether it is the last.
    stage_d   = stage_q;
    stage_v_d = stage_v_q;
    if (emit_v) begin
      stage_d   = emit_r;
      stage_v_d = 1'b1;
    end
    if (st_q == S_DONE) stage_v_d = 1'b0;
  end

  assign cmd_pop_o  = en && (st_q == S_IDLE) && !cmd_empty_i;
  assign res_push_o = en && stage_v_q && (emit_v || (st_q == S_DONE));
  always_comb begin
    res_o      = stage_q;
    res_o.last = (st_q == S_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      fret_q    <= S_IDLE;
      ph_q      <= 1'b0;
      zcnt_q    <= 2'd0;
      k_q       <= 2'd0;
      fidx_q    <= '0;
      pos_q     <= '0;
      rcnt_q    <= 5'd0;
      vstep_q   <= VS_OID;
      verid_q   <= 4'd1;
      unit_q    <= NoCode;
      prev_q    <= NoCode;
      len_q     <= '0;
      fhb_q     <= 1'b0;
      inc_q     <= 5'd0;
      stage_v_q <= 1'b0;
    end else if (en) begin
      st_q      <= st_d;
      fret_q    <= fret_d;
      ph_q      <= ph_d;
      zcnt_q    <= zcnt_d;
      k_q       <= k_d;
      fidx_q    <= fidx_d;
      pos_q     <= pos_d;
      rcnt_q    <= rcnt_d;
      vstep_q   <= vstep_d;
      verid_q   <= verid_d;
      unit_q    <= unit_d;
      prev_q    <= prev_d;
      len_q     <= len_d;
      fhb_q     <= fhb_d;
      inc_q     <= inc_d;
      stage_v_q <= stage_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_q   <= cmd_d;
      acc_q   <= acc_d;
      hold_q  <= hold_d;
      cap_q   <= cap_d;
      stage_q <= stage_d;
    end
  end

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result transfer into a full queue");

  a_idle_stage_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> !stage_v_q)
    else $error("result left in the stage between input items");

  a_pop_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (st_q != S_IDLE))
    else $error("command taken but engine stayed idle");

endmodule

[hw/rtl/mpeg4_es_frame_splitter.sv]
// Top level of the MPEG-4 Part 2 elementary stream frame splitter.
//
// Input channel: a stream byte with its end_of_data flag is transferred on a
// rising edge with push high and full low. Result channel: while empty is low
// the oldest result (kept byte or frame-end marker, with last on the final
// result of its input byte) is on the outputs; it is transferred on a rising
// edge with pop high. A prefix classifier turns every byte into a command for
// a four-entry queue; the unit engine runs the commands and feeds a
// four-entry result queue.
// The single engine works through one command at a time in a series of
// states, while the command queue takes in further bytes: it commits pending
// zeros and the byte, flushes a held small VOP unit byte by byte, scans held
// bits for the vop_coded check, and parses the VOL header at the end of a VOL
// unit. The first result of a byte passes the command queue, the engine and
// its result stage before it reaches the result queue.
// Reset empties both queues and returns the stream state to no open unit.
// When the receiver stops popping, the result queue fills, the engine stalls,
// and full rises once the command queue is full; nothing is dropped.
`timescale 1ns / 1ps
module mpeg4_es_frame_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] stream_byte_i,
  input  logic       end_of_data_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       is_frame_end_o,
  output logic       last_o
);
  import mesfs_pkg::*;

  cmd_t    cmd_in, cmd_out;
  logic    accept, cmd_pop, cmd_empty, res_push, res_full;
  result_t res_in, res_out;

  assign accept = push && !full;

  mesfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .stream_byte_i (stream_byte_i),
    .end_of_data_i (end_of_data_i),
    .cmd_o         (cmd_in)
  );

  mesfs_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  mesfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  mesfs_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign out_byte_o     = res_out.out_byte;
  assign is_frame_end_o = res_out.is_frame_end;
  assign last_o         = res_out.last;

endmodule

[dv/mpeg4_es_frame_splitter_test.sv]
// Self-checking testbench of the MPEG-4 Part 2 elementary stream frame splitter.
`timescale 1ns / 1ps
module mpeg4_es_frame_splitter_test;
  import mesfs_pkg::*;

  localparam int StallLimit = 6000;
  localparam int ItemTarget = 150;
  localparam int MaxPerByte = 24;

  typedef struct {
    logic [7:0] data;
    logic       eod;
  } stream_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] stream_byte_i = 8'h00;
  logic       end_of_data_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       is_frame_end_o;
  logic       last_o;

  stream_item_t pending_bytes[$];
  result_t      expected_results[$];
  int           total_items;
  int           accepted_items = 0;
  int           error_count = 0;
  int           idle_cycles = 0;

  // Predicted splitter state.
  logic [1:0] zeros_seen;
  logic [7:0] open_code;
  logic [7:0] last_code;
  int         open_len;
  logic [7:0] held_bytes[HoldDepth];
  logic [7:0] vol_header[CaptureDepth];
  logic       frame_open;
  int         inc_bits;
  int         step_results;

  mpeg4_es_frame_splitter i_dut (
    .clk_i, .rst_ni, .push, .full, .stream_byte_i, .end_of_data_i,
    .empty, .pop, .out_byte_o, .is_frame_end_o, .last_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void emit_result(logic [7:0] b, logic marker);
    result_t r;
    if (step_results < MaxPerByte) begin
      r.out_byte = marker ? 8'h00 : b;
      r.is_frame_end = marker;
      r.last = 1'b0;
      expected_results.push_back(r);
      step_results++;
    end
  endfunction

  function automatic void keep_byte(logic [7:0] b);
    emit_result(b, 1'b0);
    frame_open = 1'b1;
  endfunction

  function automatic bit is_vol_code(logic [7:0] c);
    return c >= VolFirst && c <= VolLast;
  endfunction

  function automatic bit holding_vop();
    return open_code == VopCode && open_len < SmallVopLimit;
  endfunction

  function automatic void release_held();
    for (int i = 0; i < open_len && i < HoldDepth; i++) keep_byte(held_bytes[i]);
  endfunction

  function automatic void commit_byte(logic [7:0] b);
    if (holding_vop()) begin
      if (open_len < HoldDepth) held_bytes[open_len] = b;
      open_len++;
      if (open_len >= SmallVopLimit) release_held();
      return;
    end
    if (is_vol_code(open_code) && open_len >= 4 && open_len - 4 < CaptureDepth)
      vol_header[open_len - 4] = b;
    keep_byte(b);
    if (open_len < LengthCap) open_len++;
  endfunction

  function automatic bit held_bit(int pos);
    int idx;
    idx = pos >> 3;
    if (idx >= open_len || idx >= HoldDepth) return 1'b0;
    return held_bytes[idx][7 - (pos & 7)];
  endfunction

  function automatic bit vop_is_coded();
    int pos;
    pos = 34;
    while (held_bit(pos)) pos++;
    pos += 3 + inc_bits;
    return held_bit(pos);
  endfunction

  function automatic int header_bits(ref int pos, input int n);
    int v;
    int idx;
    v = 0;
    for (int i = 0; i < n; i++) begin
      idx = pos >> 3;
      v = (v << 1) | ((idx < CaptureDepth) ? vol_header[idx][7 - (pos & 7)] : 0);
      pos++;
    end
    return v;
  endfunction

  function automatic void parse_vol_header();
    int pos;
    int verid;
    int shape;
    logic [15:0] v;
    int n;
    pos = 9;
    verid = 1;
    n = 0;
    if (header_bits(pos, 1) != 0) begin
      verid = header_bits(pos, 4);
      pos += 3;
    end
    if (header_bits(pos, 4) == 15) pos += 16;
    if (header_bits(pos, 1) != 0) begin
      pos += 3;
      if (header_bits(pos, 1) != 0) pos += VbvParamBits;
    end
    shape = header_bits(pos, 2);
    if (shape == 3 && verid != 1) pos += 4;
    pos += 1;
    v = 16'(header_bits(pos, 16)) - 16'd1;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    inc_bits = (n < 1) ? 1 : n;
  endfunction

  function automatic void close_unit();
    if (holding_vop()) begin
      if (vop_is_coded()) release_held();
    end else if (is_vol_code(open_code)) begin
      parse_vol_header();
    end
  endfunction

  function automatic void open_unit(logic [7:0] c);
    bit starts_frame;
    bit after_vop;
    starts_frame = c == VosCode || c == GvopCode || c == VopCode || c <= VoLast;
    after_vop = last_code == VopCode || (last_code == NoCode && c == VopCode);
    if (frame_open && starts_frame && after_vop) begin
      emit_result(8'h00, 1'b1);
      frame_open = 1'b0;
    end
    open_code = c;
    open_len = 4;
    if (is_vol_code(c)) foreach (vol_header[i]) vol_header[i] = 8'h00;
    if (holding_vop()) begin
      held_bytes[0] = 8'h00;
      held_bytes[1] = 8'h00;
      held_bytes[2] = 8'h01;
      held_bytes[3] = c;
    end else begin
      keep_byte(8'h00);
      keep_byte(8'h00);
      keep_byte(8'h01);
      keep_byte(c);
    end
  endfunction

  function automatic void clear_stream();
    zeros_seen = 2'd0;
    open_code = NoCode;
    last_code = NoCode;
    open_len = 0;
    frame_open = 1'b0;
  endfunction

  function automatic void splitter_step(stream_item_t it);
    int zeros;
    result_t r;
    step_results = 0;
    if (zeros_seen == PrefixSeen) begin
      open_unit(it.data);
      zeros_seen = 2'd0;
    end else if (it.data == 8'h00) begin
      if (zeros_seen < 2) zeros_seen++;
      else commit_byte(8'h00);
    end else if (it.data == 8'h01 && zeros_seen == 2) begin
      close_unit();
      last_code = open_code;
      open_code = NoCode;
      open_len = 0;
      zeros_seen = PrefixSeen;
    end else begin
      for (int i = 0; i < zeros_seen; i++) commit_byte(8'h00);
      zeros_seen = 2'd0;
      commit_byte(it.data);
    end
    if (it.eod) begin
      if (zeros_seen == PrefixSeen) begin
        keep_byte(8'h00);
        keep_byte(8'h00);
        keep_byte(8'h01);
      end else begin
        zeros = zeros_seen;
        zeros_seen = 2'd0;
        for (int i = 0; i < zeros; i++) commit_byte(8'h00);
        close_unit();
      end
      if (frame_open) emit_result(8'h00, 1'b1);
      clear_stream();
    end
    if (step_results > 0) begin
      r = expected_results.pop_back();
      r.last = 1'b1;
      expected_results.push_back(r);
    end
  endfunction

  task automatic add_byte(logic [7:0] b, logic eod = 1'b0);
    stream_item_t it;
    it.data = b;
    it.eod = eod;
    pending_bytes.push_back(it);
  endtask

  task automatic add_bits(ref bit bits[$]);
    logic [7:0] b;
    while (bits.size() % 8 != 0) bits.push_back(1'($urandom));
    for (int i = 0; i < bits.size(); i += 8) begin
      for (int k = 0; k < 8; k++) b[7 - k] = bits[i + k];
      add_byte(b);
    end
  endtask

  task automatic push_field(ref bit bits[$], input int v, input int n);
    for (int i = n - 1; i >= 0; i--) bits.push_back(v[i]);
  endtask

  task automatic add_prefix(logic [7:0] c);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h01);
    add_byte(c);
  endtask

  // VOL header with the fields that lead to the time resolution.
  task automatic add_vol(int res, int shape, bit with_id, int verid);
    bit bits[$];
    add_prefix(8'(VolFirst + $urandom_range(0, 15)));
    push_field(bits, $urandom, 9);
    bits.push_back(with_id);
    if (with_id) begin
      push_field(bits, verid, 4);
      push_field(bits, $urandom, 3);
    end
    if ($urandom_range(0, 4) == 0) begin
      push_field(bits, 15, 4);
      push_field(bits, $urandom, 16);
    end else begin
      push_field(bits, $urandom_range(0, 14), 4);
    end
    if ($urandom_range(0, 3) == 0) begin
      bits.push_back(1'b1);
      push_field(bits, $urandom, 3);
      bits.push_back(1'b0);
    end else begin
      bits.push_back(1'b0);
    end
    push_field(bits, shape, 2);
    if (shape == 3 && verid != 1) push_field(bits, $urandom, 4);
    bits.push_back(1'b1);
    push_field(bits, res, 16);
    add_bits(bits);
  endtask

  // VOP unit with a chosen coded bit; body_len sets the least number of bytes after the code.
  task automatic add_vop(bit coded, int incs, int body_len);
    bit bits[$];
    add_prefix(VopCode);
    push_field(bits, $urandom, 2);
    repeat ($urandom_range(0, 3)) bits.push_back(1'b1);
    bits.push_back(1'b0);
    bits.push_back(1'b1);
    push_field(bits, $urandom, incs);
    bits.push_back(1'b1);
    bits.push_back(coded);
    while (bits.size() < body_len * 8) bits.push_back(1'($urandom));
    add_bits(bits);
  endtask

  task automatic add_random_unit();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      add_vop($urandom_range(0, 3) != 0, $urandom_range(1, 16),
              ($urandom_range(0, 5) == 0) ? $urandom_range(16, 30) : $urandom_range(0, 14));
    end else if (kind < 6) begin
      add_vol($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom_range(0, 65535),
              $urandom_range(0, 3), 1'($urandom), $urandom_range(0, 15));
    end else begin
      case ($urandom_range(0, 3))
        0: add_prefix(VosCode);
        1: add_prefix(GvopCode);
        2: add_prefix(8'($urandom_range(0, VoLast)));
        default: add_prefix(8'($urandom));
      endcase
      repeat ($urandom_range(0, 6)) add_byte(8'($urandom));
    end
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 4)) add_byte(8'h00);
    if ($urandom_range(0, 11) == 0) add_byte(8'($urandom), 1'b1);
  endtask

  function automatic int phase_of(int n);
    return (n * 3) / total_items;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Driver: new item is presented once the current one has been transferred.
  always @(posedge clk_i) begin
    int ph;
    if (rst_ni) begin
      if (push && !full) begin
        splitter_step(pending_bytes.pop_front());
        accepted_items++;
      end
      ph = phase_of(accepted_items);
      if (pending_bytes.size() > 0 && !(ph == 0 && $urandom_range(0, 99) < 11)
          && !(ph == 1 && $urandom_range(0, 99) < 81)) begin
        push <= 1'b1;
        stream_byte_i <= pending_bytes[0].data;
        end_of_data_i <= pending_bytes[0].eod;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    int ph;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result byte", out_byte_o, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_byte_o !== want.out_byte)
            report_mismatch("out_byte", out_byte_o, want.out_byte);
          if (is_frame_end_o !== want.is_frame_end)
            report_mismatch("is_frame_end", is_frame_end_o, want.is_frame_end);
          if (last_o !== want.last) report_mismatch("last", last_o, want.last);
        end
      end
      ph = phase_of(accepted_items);
      pop <= !(ph == 0 && $urandom_range(0, 99) < 81) && !(ph == 1 && $urandom_range(0, 99) < 11);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no transfer for %0d cycles", StallLimit);
        $display("mpeg4_es_frame_splitter regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int target;
    clear_stream();
    inc_bits = 0;
    foreach (held_bytes[i]) held_bytes[i] = 8'h00;
    foreach (vol_header[i]) vol_header[i] = 8'h00;

    // Directed: extremes, bytes before any prefix, a code byte of zero,
    // short units, resolutions zero and one, grayscale shape, end of data
    // inside a prefix and with pending zeros.
    add_byte(8'hff);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h01);
    add_byte(8'h00);
    add_byte(8'h7f, 1'b1);
    add_vol(0, 0, 1'b0, 1);
    add_vop(1'b0, 16, 3);
    add_vop(1'b1, 16, 0);
    add_vol(1, 3, 1'b1, 2);
    add_vop(1'b1, 1, 20);
    add_prefix(VosCode);
    add_byte(8'h00);
    add_byte(8'h00, 1'b1);
    add_prefix(VopCode);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h01, 1'b1);

    target = ItemTarget;
    while (pending_bytes.size() < target) begin
      if ($urandom_range(0, 9) == 0) add_byte(8'($urandom), 1'($urandom_range(0, 15) == 0));
      else add_random_unit();
    end
    total_items = pending_bytes.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_bytes.size() == 0 && expected_results.size() == 0);
    repeat (400) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) $display("mpeg4_es_frame_splitter regression: pass");
    else $display("mpeg4_es_frame_splitter regression: fail");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mesfs_pkg.sv
hw/rtl/mesfs_cmd_queue.sv
hw/rtl/mesfs_res_queue.sv
hw/rtl/mesfs_front.sv
hw/rtl/mesfs_back.sv
hw/rtl/mpeg4_es_frame_splitter.sv
dv/mpeg4_es_frame_splitter_test.sv
